[rtl/pts_pkg.sv]
// Package of the priority thread scheduler: command, status and sequencer codes.
`default_nettype none
package pts_pkg;

  localparam logic [7:0] PRIO_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_ADD     = 3'd1,
    ACT_KILL    = 3'd2,
    ACT_SLEEP   = 3'd3,
    ACT_BLOCK   = 3'd4,
    ACT_SCHED   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_LAST     = 2'd2,
    ST_NO_THR   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_WR1,
    S_ADD_WR2,
    S_KILL_WR,
    S_PARK_RD,
    S_PARK_EMPTY,
    S_PARK_HEAD,
    S_PARK_FRONT2,
    S_PARK_WN,
    S_PARK_WW,
    S_PARK_INS1,
    S_PARK_INS2,
    S_WAKE_ISSUE,
    S_WAKE_CHK,
    S_WAKE_LINK1,
    S_WAKE_LINK2,
    S_WAKE_LINK3,
    S_SCAN_ISSUE,
    S_SCAN_FIRST,
    S_SCAN,
    S_DONE
  } seq_state_t;

endpackage
`default_nettype wire

[rtl/pts_ram.sv]
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule
`default_nettype wire

[rtl/priority_thread_scheduler.sv]
// Top level of the priority thread scheduler: command sequencer over the thread tables.
//
// Usage:
//   The in_ channel carries one command per transfer (tick, add, kill, sleep
//   current, set blocked, schedule). Every command produces exactly one
//   result transfer on the out_ channel with the running thread, a status,
//   the slot of an added thread, the switch request and the live count.
//   Links, priorities and wake times live in four RAMs with registered reads;
//   the alive, asleep, blocked and parked marks live in flip-flops.
//   Tick, sleep, set blocked and the first add go straight from the accept
//   step to the result step; a later add writes the links in two steps and
//   a kill in one. Schedule parks a sleeping current thread in the sleep
//   list by wake time when others are awake, wakes the due sleepers from
//   the list head, then scans the ring over the link RAM one entry a cycle.
//   One command is worked at a time; in_tready is high while the sequencer
//   is idle, also when a finished result still waits on out_.
//   Reset (rst_n low, synchronous) clears all marks and counters, empties
//   the sleep list and sets system time to zero; the RAMs need no clear.
//   When the receiver stalls, the result holds in the output register and
//   the sequencer holds its final step until the slot frees.
`default_nettype none
module priority_thread_scheduler #(
  parameter int THREAD_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // action[2:0], thread_sel[6:3], new_priority[14:7], sleep_duration[46:15],
  // blocked_flag[47]
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // running_thread[3:0], status[5:4], added_id[9:6], switch_request[10],
  // live_threads[15:11]
  output logic      [15:0] out_tdata
);

  localparam int IW = $clog2(THREAD_SLOTS);
  localparam int LW = $clog2(THREAD_SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(THREAD_SLOTS);

  // Input fields
  logic [2:0]  f_action;
  logic [3:0]  f_sel;
  logic [7:0]  f_prio;
  logic [31:0] f_dur;
  logic        f_flag;
  assign f_action = in_tdata[2:0];
  assign f_sel    = in_tdata[6:3];
  assign f_prio   = in_tdata[14:7];
  assign f_dur    = in_tdata[46:15];
  assign f_flag   = in_tdata[47];

  logic [31:0]   sel_w;
  logic [IW-1:0] sel_ix;
  logic          sel_ok;
  assign sel_w  = 32'(f_sel);
  assign sel_ix = sel_w[IW-1:0];
  assign sel_ok = (sel_w < 32'(THREAD_SLOTS));

  function automatic logic [IW-1:0] ix(input logic [LW-1:0] v);
    return v[IW-1:0];
  endfunction

  // Control and payload registers
  pts_pkg::seq_state_t state_r, state_nxt;
  logic [THREAD_SLOTS-1:0] alive_r, alive_nxt;
  logic [THREAD_SLOTS-1:0] asleep_r, asleep_nxt;
  logic [THREAD_SLOTS-1:0] blocked_r, blocked_nxt;
  logic [THREAD_SLOTS-1:0] parked_r, parked_nxt;
  logic [LW-1:0]  head_r, head_nxt;
  logic [LW-1:0]  scnt_r, scnt_nxt;
  logic [LW-1:0]  tcnt_r, tcnt_nxt;
  logic [IW-1:0]  cur_r, cur_nxt;
  logic [31:0]    time_r, time_nxt;
  logic [IW-1:0]  t_r, t_nxt;
  logic [IW-1:0]  c_r, c_nxt;
  logic [LW-1:0]  p_r, p_nxt;
  logic [LW-1:0]  n_r, n_nxt;
  logic [LW-1:0]  it_r, it_nxt;
  logic [31:0]    wt_r, wt_nxt;
  logic [7:0]     best_r, best_nxt;
  logic [LW-1:0]  cnt_r, cnt_nxt;
  logic [1:0]     status_r, status_nxt;
  logic [IW-1:0]  added_r, added_nxt;
  logic           sw_r, sw_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [15:0]    out_data_r, out_data_nxt;

  // RAM ports
  logic          nx_we, pv_we, pr_we, wk_we;
  logic [IW-1:0] nx_wa, pv_wa, pr_wa, wk_wa;
  logic [LW-1:0] nx_wd, pv_wd;
  logic [7:0]    pr_wd;
  logic [31:0]   wk_wd;
  logic [IW-1:0] nx_ra, pv_ra, pr_ra, wk_ra;
  logic [LW-1:0] nx_rd, pv_rd;
  logic [7:0]    pr_rd;
  logic [31:0]   wk_rd;

  pts_ram #(.WIDTH(LW), .DEPTH(THREAD_SLOTS)) u_next_ram (
    .clk(clk), .we(nx_we), .wa(nx_wa), .wd(nx_wd), .ra(nx_ra), .rd(nx_rd)
  );
  pts_ram #(.WIDTH(LW), .DEPTH(THREAD_SLOTS)) u_prev_ram (
    .clk(clk), .we(pv_we), .wa(pv_wa), .wd(pv_wd), .ra(pv_ra), .rd(pv_rd)
  );
  pts_ram #(.WIDTH(8), .DEPTH(THREAD_SLOTS)) u_prio_ram (
    .clk(clk), .we(pr_we), .wa(pr_wa), .wd(pr_wd), .ra(pr_ra), .rd(pr_rd)
  );
  pts_ram #(.WIDTH(32), .DEPTH(THREAD_SLOTS)) u_wake_ram (
    .clk(clk), .we(wk_we), .wa(wk_wa), .wd(wk_wd), .ra(wk_ra), .rd(wk_rd)
  );

  // Lowest dead slot for an add
  logic [IW-1:0] spot;
  logic          spot_ok;
  always_comb begin
    spot    = '0;
    spot_ok = 1'b0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (!alive_r[i]) begin
        spot    = IW'(i);
        spot_ok = 1'b1;
      end
    end
  end

  // Threads in the ready ring
  logic [LW-1:0] awake;
  assign awake = (scnt_r >= tcnt_r) ? '0 : (tcnt_r - scnt_r);

  logic in_fire;
  assign in_tready = (state_r == pts_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  logic [31:0] cur_w, added_w, tcnt_w;
  assign cur_w   = 32'(cur_r);
  assign added_w = 32'(added_r);
  assign tcnt_w  = 32'(tcnt_r);

  always_comb begin
    state_nxt     = state_r;
    alive_nxt     = alive_r;
    asleep_nxt    = asleep_r;
    blocked_nxt   = blocked_r;
    parked_nxt    = parked_r;
    head_nxt      = head_r;
    scnt_nxt      = scnt_r;
    tcnt_nxt      = tcnt_r;
    cur_nxt       = cur_r;
    time_nxt      = time_r;
    t_nxt         = t_r;
    c_nxt         = c_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    it_nxt        = it_r;
    wt_nxt        = wt_r;
    best_nxt      = best_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    added_nxt     = added_r;
    sw_nxt        = sw_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    pr_we = 1'b0; pr_wa = '0; pr_wd = '0;
    wk_we = 1'b0; wk_wa = '0; wk_wd = '0;
    nx_ra = cur_r;
    pv_ra = cur_r;
    pr_ra = cur_r;
    wk_ra = cur_r;

    case (state_r)
      pts_pkg::S_IDLE: begin
        if (in_fire) begin
          status_nxt = pts_pkg::ST_OK;
          added_nxt  = '0;
          sw_nxt     = 1'b0;
          state_nxt  = pts_pkg::S_DONE;
          case (f_action)
            pts_pkg::ACT_TICK: begin
              time_nxt = time_r + 32'd1;
            end
            pts_pkg::ACT_ADD: begin
              if (tcnt_r >= LW'(THREAD_SLOTS) || !spot_ok) begin
                status_nxt = pts_pkg::ST_FULL;
              end else begin
                pr_we = 1'b1; pr_wa = spot; pr_wd = f_prio;
                alive_nxt[spot]   = 1'b1;
                asleep_nxt[spot]  = 1'b0;
                blocked_nxt[spot] = 1'b0;
                tcnt_nxt  = tcnt_r + LW'(1);
                added_nxt = spot;
                t_nxt     = spot;
                c_nxt     = cur_r;
                if (tcnt_r == '0) begin
                  nx_we = 1'b1; nx_wa = spot; nx_wd = LW'(spot);
                  pv_we = 1'b1; pv_wa = spot; pv_wd = LW'(spot);
                  cur_nxt = spot;
                end else begin
                  // fetch the predecessor of the current thread
                  pv_ra     = cur_r;
                  state_nxt = pts_pkg::S_ADD_WR1;
                end
                if (time_r == 32'd0) begin
                  cur_nxt = spot;
                end
              end
            end
            pts_pkg::ACT_KILL: begin
              if (tcnt_r <= LW'(1)) begin
                status_nxt = pts_pkg::ST_LAST;
              end else if (!sel_ok || !alive_r[sel_ix]) begin
                status_nxt = pts_pkg::ST_NO_THR;
              end else if (!parked_r[sel_ix] && awake <= LW'(1)) begin
                status_nxt = pts_pkg::ST_LAST;
              end else begin
                t_nxt     = sel_ix;
                nx_ra     = sel_ix;
                pv_ra     = sel_ix;
                state_nxt = pts_pkg::S_KILL_WR;
              end
            end
            pts_pkg::ACT_SLEEP: begin
              if (tcnt_r != '0) begin
                wk_we = 1'b1; wk_wa = cur_r; wk_wd = f_dur + time_r;
                asleep_nxt[cur_r] = 1'b1;
                sw_nxt = 1'b1;
              end
            end
            pts_pkg::ACT_BLOCK: begin
              if (!sel_ok || !alive_r[sel_ix]) begin
                status_nxt = pts_pkg::ST_NO_THR;
              end else begin
                blocked_nxt[sel_ix] = f_flag;
              end
            end
            pts_pkg::ACT_SCHED: begin
              if (tcnt_r != '0) begin
                state_nxt = pts_pkg::S_WAKE_ISSUE;
                if (asleep_r[cur_r] && alive_r[cur_r] && !parked_r[cur_r]) begin
                  if (awake <= LW'(1)) begin
                    asleep_nxt[cur_r] = 1'b0;
                  end else begin
                    t_nxt = cur_r;
                    nx_ra = cur_r;
                    pv_ra = cur_r;
                    wk_ra = cur_r;
                    state_nxt = pts_pkg::S_PARK_RD;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      pts_pkg::S_ADD_WR1: begin
        p_nxt = pv_rd;
        nx_we = 1'b1; nx_wa = t_r; nx_wd = LW'(c_r);
        pv_we = 1'b1; pv_wa = c_r; pv_wd = LW'(t_r);
        state_nxt = pts_pkg::S_ADD_WR2;
      end

      pts_pkg::S_ADD_WR2: begin
        nx_we = 1'b1; nx_wa = ix(p_r); nx_wd = LW'(t_r);
        pv_we = 1'b1; pv_wa = t_r; pv_wd = p_r;
        state_nxt = pts_pkg::S_DONE;
      end

      pts_pkg::S_KILL_WR: begin
        if (parked_r[t_r]) begin
          if (pv_rd != NIL) begin
            nx_we = 1'b1; nx_wa = ix(pv_rd); nx_wd = nx_rd;
          end
          if (nx_rd != NIL) begin
            pv_we = 1'b1; pv_wa = ix(nx_rd); pv_wd = pv_rd;
          end
          if (head_r == LW'(t_r)) begin
            head_nxt = nx_rd;
          end
          if (scnt_r != '0) begin
            scnt_nxt = scnt_r - LW'(1);
          end
          parked_nxt[t_r] = 1'b0;
        end else begin
          pv_we = 1'b1; pv_wa = ix(nx_rd); pv_wd = pv_rd;
          nx_we = 1'b1; nx_wa = ix(pv_rd); nx_wd = nx_rd;
          if (cur_r == t_r) begin
            cur_nxt = ix(pv_rd);
            sw_nxt  = 1'b1;
          end
        end
        alive_nxt[t_r]   = 1'b0;
        asleep_nxt[t_r]  = 1'b0;
        blocked_nxt[t_r] = 1'b0;
        tcnt_nxt  = tcnt_r - LW'(1);
        state_nxt = pts_pkg::S_DONE;
      end

      pts_pkg::S_PARK_RD: begin
        // unlink from the ring; the predecessor runs on
        wt_nxt  = wk_rd;
        cur_nxt = ix(pv_rd);
        pv_we = 1'b1; pv_wa = ix(nx_rd); pv_wd = pv_rd;
        nx_we = 1'b1; nx_wa = ix(pv_rd); nx_wd = nx_rd;
        scnt_nxt = scnt_r + LW'(1);
        parked_nxt[t_r] = 1'b1;
        if (head_r == NIL) begin
          state_nxt = pts_pkg::S_PARK_EMPTY;
        end else begin
          wk_ra     = ix(head_r);
          state_nxt = pts_pkg::S_PARK_HEAD;
        end
      end

      pts_pkg::S_PARK_EMPTY: begin
        nx_we = 1'b1; nx_wa = t_r; nx_wd = NIL;
        pv_we = 1'b1; pv_wa = t_r; pv_wd = NIL;
        head_nxt  = LW'(t_r);
        state_nxt = pts_pkg::S_WAKE_ISSUE;
      end

      pts_pkg::S_PARK_HEAD: begin
        if (wk_rd > wt_r) begin
          nx_we = 1'b1; nx_wa = t_r; nx_wd = head_r;
          pv_we = 1'b1; pv_wa = ix(head_r); pv_wd = LW'(t_r);
          head_nxt  = LW'(t_r);
          state_nxt = pts_pkg::S_PARK_FRONT2;
        end else begin
          it_nxt    = head_r;
          nx_ra     = ix(head_r);
          state_nxt = pts_pkg::S_PARK_WN;
        end
      end

      pts_pkg::S_PARK_FRONT2: begin
        pv_we = 1'b1; pv_wa = t_r; pv_wd = NIL;
        state_nxt = pts_pkg::S_WAKE_ISSUE;
      end

      pts_pkg::S_PARK_WN: begin
        n_nxt = nx_rd;
        if (nx_rd == NIL) begin
          state_nxt = pts_pkg::S_PARK_INS1;
        end else begin
          wk_ra     = ix(nx_rd);
          state_nxt = pts_pkg::S_PARK_WW;
        end
      end

      pts_pkg::S_PARK_WW: begin
        if (wk_rd >= wt_r) begin
          state_nxt = pts_pkg::S_PARK_INS1;
        end else begin
          // advance along the sleep list
          it_nxt    = n_r;
          nx_ra     = ix(n_r);
          state_nxt = pts_pkg::S_PARK_WN;
        end
      end

      pts_pkg::S_PARK_INS1: begin
        nx_we = 1'b1; nx_wa = t_r; nx_wd = n_r;
        pv_we = 1'b1; pv_wa = t_r; pv_wd = it_r;
        state_nxt = pts_pkg::S_PARK_INS2;
      end

      pts_pkg::S_PARK_INS2: begin
        nx_we = 1'b1; nx_wa = ix(it_r); nx_wd = LW'(t_r);
        if (n_r != NIL) begin
          pv_we = 1'b1; pv_wa = ix(n_r); pv_wd = LW'(t_r);
        end
        state_nxt = pts_pkg::S_WAKE_ISSUE;
      end

      pts_pkg::S_WAKE_ISSUE: begin
        if (head_r == NIL) begin
          state_nxt = pts_pkg::S_SCAN_ISSUE;
        end else begin
          wk_ra     = ix(head_r);
          state_nxt = pts_pkg::S_WAKE_CHK;
        end
      end

      pts_pkg::S_WAKE_CHK: begin
        if (wk_rd < time_r) begin
          t_nxt = ix(head_r);
          asleep_nxt[ix(head_r)] = 1'b0;
          parked_nxt[ix(head_r)] = 1'b0;
          nx_ra     = ix(head_r);
          pv_ra     = cur_r;
          state_nxt = pts_pkg::S_WAKE_LINK1;
        end else begin
          state_nxt = pts_pkg::S_SCAN_ISSUE;
        end
      end

      pts_pkg::S_WAKE_LINK1: begin
        head_nxt = nx_rd;
        p_nxt    = pv_rd;
        if (nx_rd != NIL) begin
          pv_we = 1'b1; pv_wa = ix(nx_rd); pv_wd = NIL;
        end
        nx_we = 1'b1; nx_wa = t_r; nx_wd = LW'(cur_r);
        state_nxt = pts_pkg::S_WAKE_LINK2;
      end

      pts_pkg::S_WAKE_LINK2: begin
        pv_we = 1'b1; pv_wa = t_r; pv_wd = p_r;
        nx_we = 1'b1; nx_wa = ix(p_r); nx_wd = LW'(t_r);
        state_nxt = pts_pkg::S_WAKE_LINK3;
      end

      pts_pkg::S_WAKE_LINK3: begin
        pv_we = 1'b1; pv_wa = cur_r; pv_wd = LW'(t_r);
        cur_nxt = t_r;
        if (scnt_r != '0) begin
          scnt_nxt = scnt_r - LW'(1);
        end
        state_nxt = pts_pkg::S_WAKE_ISSUE;
      end

      pts_pkg::S_SCAN_ISSUE: begin
        best_nxt = pts_pkg::PRIO_MAX;
        cnt_nxt  = LW'(1);
        if (tcnt_r <= LW'(1)) begin
          state_nxt = pts_pkg::S_DONE;
        end else begin
          nx_ra     = cur_r;
          state_nxt = pts_pkg::S_SCAN_FIRST;
        end
      end

      pts_pkg::S_SCAN_FIRST: begin
        it_nxt    = nx_rd;
        nx_ra     = ix(nx_rd);
        pr_ra     = ix(nx_rd);
        state_nxt = pts_pkg::S_SCAN;
      end

      pts_pkg::S_SCAN: begin
        // one ring entry a cycle; a tie goes to the later thread
        if (it_r < NIL && !asleep_r[ix(it_r)] && !blocked_r[ix(it_r)] &&
            pr_rd <= best_r) begin
          cur_nxt  = ix(it_r);
          best_nxt = pr_rd;
        end
        if (cnt_r == tcnt_r - LW'(1)) begin
          state_nxt = pts_pkg::S_DONE;
        end else begin
          cnt_nxt = cnt_r + LW'(1);
          it_nxt  = nx_rd;
          nx_ra   = ix(nx_rd);
          pr_ra   = ix(nx_rd);
        end
      end

      pts_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {tcnt_w[4:0], sw_r, added_w[3:0], status_r, cur_w[3:0]};
          state_nxt     = pts_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pts_pkg::S_IDLE;
      alive_r     <= '0;
      asleep_r    <= '0;
      blocked_r   <= '0;
      parked_r    <= '0;
      head_r      <= NIL;
      scnt_r      <= '0;
      tcnt_r      <= '0;
      cur_r       <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alive_r     <= alive_nxt;
      asleep_r    <= asleep_nxt;
      blocked_r   <= blocked_nxt;
      parked_r    <= parked_nxt;
      head_r      <= head_nxt;
      scnt_r      <= scnt_nxt;
      tcnt_r      <= tcnt_nxt;
      cur_r       <= cur_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    c_r        <= c_nxt;
    p_r        <= p_nxt;
    n_r        <= n_nxt;
    it_r       <= it_nxt;
    wt_r       <= wt_nxt;
    best_r     <= best_nxt;
    cnt_r      <= cnt_nxt;
    status_r   <= status_nxt;
    added_r    <= added_nxt;
    sw_r       <= sw_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
